// File: design/lwh_pkg.sv
// ----------------------------------------------------------------------------
// lwh_pkg
// shared types, register indexes and link state codes for the link watchdog
// ----------------------------------------------------------------------------
`default_nettype none

package lwh_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [COUNT_W:0] COUNT_MAX = 17'd65535;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_TIMEOUT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HB_PERIOD      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGITAL_IN_EN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANALOG_IN_EN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGITAL_OUT_EN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANALOG_OUT_EN  = 3'd5;

   typedef logic signed [1:0] link_state_type;

   localparam link_state_type LINK_NONE  = 2'sb00;
   localparam link_state_type LINK_ALIVE = 2'sb01;
   localparam link_state_type LINK_ERROR = 2'sb11;

   typedef struct packed {
      logic [TIME_W-1:0] error_timeout_ms;
      logic [TIME_W-1:0] heartbeat_period_ms;
      logic              digital_in_enable;
      logic              analog_in_enable;
      logic              digital_out_enable;
      logic              analog_out_enable;
   } cfg_type;

endpackage

`default_nettype wire

// File: design/lwh_link_monitor.sv
// ----------------------------------------------------------------------------
// lwh_link_monitor
// input change detection, error timeout and link state register
// ----------------------------------------------------------------------------
`default_nettype none

module lwh_link_monitor (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire lwh_pkg::cfg_type            cfg,
   input  wire logic [lwh_pkg::TIME_W-1:0]  now_ms,
   input  wire logic                        digital_level,
   input  wire logic [lwh_pkg::WORD_W-1:0]  analog_word,
   output      lwh_pkg::link_state_type     link_state
);
   import lwh_pkg::*;

   logic                  last_level_ff, last_level_in;
   logic [WORD_W-1:0]     last_word_ff, last_word_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   link_state_type        state_ff, state_in;

   logic                  digital_chg;
   logic                  analog_chg;
   logic                  any_chg;
   logic [TIME_W-1:0]     start_mid;
   logic [TIME_W-1:0]     elapsed;
   logic                  expired;
   link_state_type        state_mid;

   always_comb begin
      digital_chg = cfg.digital_in_enable && (digital_level != last_level_ff);
      analog_chg  = cfg.analog_in_enable && (analog_word != last_word_ff);
      any_chg     = digital_chg || analog_chg;

      // nothing monitored clears the state before the change checks
      if (!cfg.digital_in_enable && !cfg.analog_in_enable) begin
         state_mid = LINK_NONE;
      end else begin
         state_mid = state_ff;
      end
      if (any_chg) begin
         state_mid = LINK_ALIVE;
      end

      start_mid = any_chg ? now_ms : start_ff;
      elapsed   = now_ms - start_mid;
      expired   = (cfg.error_timeout_ms != '0) && (elapsed > cfg.error_timeout_ms);

      link_state    = expired ? LINK_ERROR : state_mid;
      start_in      = expired ? now_ms : start_mid;
      state_in      = link_state;
      last_level_in = digital_chg ? digital_level : last_level_ff;
      last_word_in  = analog_chg ? analog_word : last_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         last_word_ff  <= '0;
         start_ff      <= '0;
         state_ff      <= LINK_NONE;
      end else if (step) begin
         last_level_ff <= last_level_in;
         last_word_ff  <= last_word_in;
         start_ff      <= start_in;
         state_ff      <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/lwh_heartbeat.sv
// ----------------------------------------------------------------------------
// lwh_heartbeat
// heartbeat period timer with toggle bit and wrapping beat counter
// ----------------------------------------------------------------------------
`default_nettype none

module lwh_heartbeat (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire lwh_pkg::cfg_type            cfg,
   input  wire logic [lwh_pkg::TIME_W-1:0]  now_ms,
   output      logic                        heartbeat_bit,
   output      logic [lwh_pkg::COUNT_W-1:0] heartbeat_count
);
   import lwh_pkg::*;

   logic [TIME_W-1:0]  start_ff, start_in;
   logic               toggle_ff, toggle_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               fire;
   logic [COUNT_W:0]   count_inc;

   always_comb begin
      fire      = (now_ms - start_ff) > cfg.heartbeat_period_ms;
      count_inc = {1'b0, count_ff} + 1'b1;

      start_in  = fire ? now_ms : start_ff;
      toggle_in = (fire && cfg.digital_out_enable) ? ~toggle_ff : toggle_ff;
      count_in  = count_ff;
      if (fire && cfg.analog_out_enable) begin
         count_in = (count_inc > COUNT_MAX) ? '0 : count_inc[COUNT_W-1:0];
      end

      // outputs read zero while not driven, hidden values hold
      heartbeat_bit   = cfg.digital_out_enable ? toggle_in : 1'b0;
      heartbeat_count = cfg.analog_out_enable ? count_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         toggle_ff <= 1'b0;
         count_ff  <= '0;
      end else if (step) begin
         start_ff  <= start_in;
         toggle_ff <= toggle_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/link_watchdog_with_heartbeat.sv
// ----------------------------------------------------------------------------
// link_watchdog_with_heartbeat
// watches a digital level and an analog word for change and drives heartbeats
//
// req_ channel: one item per evaluation (now_ms, digital_level, analog_word)
// rsp_ channel: one item per request (link_state, heartbeat_bit, heartbeat_count)
// csr_ channel: register writes by index, always ready, take effect next item
// result: registered, valid in the cycle after the request is accepted
// throughput: one item per cycle while rsp_ready is high, set by the single output register; the
//   state update and all compares finish in the accept cycle
// stall: the output register holds its item while rsp_ready is low; a new
//   request is taken in the same cycle the held item leaves
// reset: synchronous, clears config registers, timers, link state and heartbeats
// ----------------------------------------------------------------------------
`default_nettype none

module link_watchdog_with_heartbeat (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [lwh_pkg::TIME_W-1:0]      req_now_ms,
   input  wire logic                            req_digital_level,
   input  wire logic [lwh_pkg::WORD_W-1:0]      req_analog_word,
   // response channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic signed [1:0]               rsp_link_state,
   output      logic                            rsp_heartbeat_bit,
   output      logic [lwh_pkg::COUNT_W-1:0]     rsp_heartbeat_count,
   // register write channel
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [lwh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lwh_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lwh_pkg::*;

   cfg_type            cfg_ff, cfg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   link_state_type     link_state_ff;
   logic               hb_bit_ff;
   logic [COUNT_W-1:0] hb_count_ff;

   logic               step;
   link_state_type     link_state;
   logic               hb_bit;
   logic [COUNT_W-1:0] hb_count;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ERROR_TIMEOUT:  cfg_in.error_timeout_ms    = csr_data[TIME_W-1:0];
            CSR_HB_PERIOD:      cfg_in.heartbeat_period_ms = csr_data[TIME_W-1:0];
            CSR_DIGITAL_IN_EN:  cfg_in.digital_in_enable   = csr_data[0];
            CSR_ANALOG_IN_EN:   cfg_in.analog_in_enable    = csr_data[0];
            CSR_DIGITAL_OUT_EN: cfg_in.digital_out_enable  = csr_data[0];
            CSR_ANALOG_OUT_EN:  cfg_in.analog_out_enable   = csr_data[0];
            default:            cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // take a request whenever the output register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   lwh_link_monitor u_link_monitor (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .cfg           (cfg_ff),
      .now_ms        (req_now_ms),
      .digital_level (req_digital_level),
      .analog_word   (req_analog_word),
      .link_state    (link_state)
   );

   lwh_heartbeat u_heartbeat (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .cfg             (cfg_ff),
      .now_ms          (req_now_ms),
      .heartbeat_bit   (hb_bit),
      .heartbeat_count (hb_count)
   );

   // output register, valid cleared when taken and not refilled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (step) begin
         link_state_ff <= link_state;
         hb_bit_ff     <= hb_bit;
         hb_count_ff   <= hb_count;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_link_state      = link_state_ff;
   assign rsp_heartbeat_bit   = hb_bit_ff;
   assign rsp_heartbeat_count = hb_count_ff;

`ifndef ASSERT_OFF
   // an accepted request always shows up as a result next cycle
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted item produced no result");

   // a stalled result is not overwritten by a new request
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while result stalled");

   // an empty output register never blocks the request side
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // undriven heartbeat count output reads zero
   a_hb_off_zero: assert property (@(posedge clock) disable iff (reset)
      (step && !cfg_ff.analog_out_enable) |=> (rsp_heartbeat_count == '0))
      else $error("heartbeat counter driven while disabled");
`endif

endmodule

`default_nettype wire
